// ----- rtl/sfu_pkg.sv -----
// sfu_pkg: shared widths and mode codes of the steering force unit.
// No dependencies; used by every module of the unit except sfu_checker.
package sfu_pkg;

    // Normalized component width: the larger magnitude of a pair sits in [2^30, 2^31).
    localparam int unsigned NrmW = 31;
    // Vector length width: floor(sqrt(nx^2 + ny^2)) < 2^32.
    localparam int unsigned LenW = 32;
    // Signed net shift count of a normalized vector.
    localparam int unsigned KW   = 7;

    typedef enum logic [2:0] {
        OP_SEEK    = 3'd0,
        OP_ARRIVE  = 3'd1,
        OP_FLEE    = 3'd2,
        OP_PURSUIT = 3'd3,
        OP_EVADE   = 3'd4
    } t_op;

endpackage

// ----- rtl/steering_force_unit_top.sv -----
// steering_force_unit_top: steering force pipeline for seek, arrive, flee,
// pursuit and evade. Depends on sfu_pkg, sfu_norm and sfu_muldiv.
//
// Usage:
//   Input channel i_valid/o_ready carries one agent word (mode, agent
//   position and velocity, speed and force limits, target position and
//   velocity, slowing radius). Output channel o_valid/i_ready carries the
//   force word (o_force_x, o_force_y), Q16.16, saturated.
//   i_cfg_we/i_cfg_data write the pursuit/evade lookahead step count; write
//   it only while the pipeline is empty.
//   A new word is taken every cycle unless the output is stalled;
//   throughput is one word per cycle, set by the fully pipelined square
//   roots (one root bit per stage) and restoring dividers (one quotient
//   bit per stage).
//   Reset (synchronous, active low) clears every stage valid bit and the
//   lookahead register to zero.
//   When the receiver holds i_ready low with a word waiting, the whole
//   pipeline freezes in place and o_ready drops; nothing is lost or
//   repeated, and bubbles stay where they are.
module steering_force_unit_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_entity_pos_x,
    input  logic signed [31:0] i_entity_pos_y,
    input  logic signed [31:0] i_entity_vel_x,
    input  logic signed [31:0] i_entity_vel_y,
    input  logic [30:0]        i_max_speed,
    input  logic [30:0]        i_max_force,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_vel_x,
    input  logic signed [31:0] i_target_vel_y,
    input  logic signed [31:0] i_slowing_radius,
    input  logic               i_cfg_we,
    input  logic [9:0]         i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y
);
    localparam int unsigned NW = sfu_pkg::NrmW;
    localparam int unsigned LW = sfu_pkg::LenW;
    localparam int unsigned KW = sfu_pkg::KW;
    localparam int unsigned DMW = 43;   // offset magnitude width
    localparam int unsigned SMW = 33;   // steering magnitude width

    typedef struct packed {
        logic               op_zero;
        logic               arrive_en;
        logic               neg_x;
        logic               neg_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        speed;
        logic [30:0]        mf;
        logic [30:0]        rad;
    } t_tag_a;

    typedef struct packed {
        logic          use_arr;
        logic [30:0]   nx;
        logic [30:0]   ny;
        logic [31:0]   len;
        t_tag_a        a;
    } t_tag_b;

    typedef struct packed {
        logic               len_zero;
        logic               neg_x;
        logic               neg_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        mf;
        logic               op_zero;
    } t_tag_c;

    typedef struct packed {
        logic               op_zero;
        logic signed [32:0] sx;
        logic signed [32:0] sy;
        logic [30:0]        mf;
    } t_tag_d;

    typedef struct packed {
        logic               over;
        logic               op_zero;
        logic signed [32:0] sx;
        logic signed [32:0] sy;
    } t_tag_e;

    function automatic logic [31:0] sat33(input logic signed [32:0] v);
        logic [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic       w_adv;
    logic       r_out_vld;
    logic [9:0] r_lookahead_steps;

    // freeze everything while a finished word waits
    assign w_adv   = !r_out_vld || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookahead_steps <= '0;
        end else if (i_cfg_we) begin
            r_lookahead_steps <= i_cfg_data;
        end
    end

    // stage 1: capture and predict target velocity steps
    logic               r1_vld;
    logic [2:0]         r1_op;
    logic signed [31:0] r1_px;
    logic signed [31:0] r1_py;
    logic signed [31:0] r1_vx;
    logic signed [31:0] r1_vy;
    logic [30:0]        r1_speed;
    logic [30:0]        r1_mf;
    logic signed [31:0] r1_tx;
    logic signed [31:0] r1_ty;
    logic signed [42:0] r1_pvx;
    logic signed [42:0] r1_pvy;
    logic signed [31:0] r1_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_op    <= i_op;
            r1_px    <= i_entity_pos_x;
            r1_py    <= i_entity_pos_y;
            r1_vx    <= i_entity_vel_x;
            r1_vy    <= i_entity_vel_y;
            r1_speed <= i_max_speed;
            r1_mf    <= i_max_force;
            r1_tx    <= i_target_x;
            r1_ty    <= i_target_y;
            r1_pvx   <= i_target_vel_x * $signed({1'b0, r_lookahead_steps});
            r1_pvy   <= i_target_vel_y * $signed({1'b0, r_lookahead_steps});
            r1_rad   <= i_slowing_radius;
        end
    end

    // stage 2: offset toward (or away from) the target, as sign and magnitude
    logic               w_pred;
    logic               w_away;
    logic signed [43:0] w_ptx;
    logic signed [43:0] w_pty;
    logic signed [44:0] w_dx;
    logic signed [44:0] w_dy;
    logic signed [44:0] w_adx;
    logic signed [44:0] w_ady;
    t_tag_a             n2_tag;
    logic               r2_vld;
    logic [DMW-1:0]     r2_magx;
    logic [DMW-1:0]     r2_magy;
    t_tag_a             r2_tag;

    always_comb begin
        w_pred = (r1_op == sfu_pkg::OP_PURSUIT) || (r1_op == sfu_pkg::OP_EVADE);
        w_away = (r1_op == sfu_pkg::OP_FLEE) || (r1_op == sfu_pkg::OP_EVADE);
        w_ptx  = {{12{r1_tx[31]}}, r1_tx};
        w_pty  = {{12{r1_ty[31]}}, r1_ty};
        if (w_pred) begin
            w_ptx = w_ptx + {r1_pvx[42], r1_pvx};
            w_pty = w_pty + {r1_pvy[42], r1_pvy};
        end
        if (w_away) begin
            w_dx = {{13{r1_px[31]}}, r1_px} - {w_ptx[43], w_ptx};
            w_dy = {{13{r1_py[31]}}, r1_py} - {w_pty[43], w_pty};
        end else begin
            w_dx = {w_ptx[43], w_ptx} - {{13{r1_px[31]}}, r1_px};
            w_dy = {w_pty[43], w_pty} - {{13{r1_py[31]}}, r1_py};
        end
        w_adx = w_dx[44] ? -w_dx : w_dx;
        w_ady = w_dy[44] ? -w_dy : w_dy;

        n2_tag.op_zero   = r1_op > sfu_pkg::OP_EVADE;
        n2_tag.arrive_en = (r1_op == sfu_pkg::OP_ARRIVE) && !r1_rad[31] && (r1_rad != '0);
        n2_tag.neg_x     = w_dx[44];
        n2_tag.neg_y     = w_dy[44];
        n2_tag.vel_x     = r1_vx;
        n2_tag.vel_y     = r1_vy;
        n2_tag.speed     = r1_speed;
        n2_tag.mf        = r1_mf;
        n2_tag.rad       = r1_rad[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_magx <= w_adx[DMW-1:0];
            r2_magy <= w_ady[DMW-1:0];
            r2_tag  <= n2_tag;
        end
    end

    // offset length
    logic                 nd_vld;
    logic [NW-1:0]        nd_nx;
    logic [NW-1:0]        nd_ny;
    logic signed [KW-1:0] nd_k;
    logic [LW-1:0]        nd_len;
    t_tag_a               nd_tag;

    sfu_norm #(
        .IW ($bits(r2_magx)),
        .TW ($bits(t_tag_a))
    ) u_norm_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r2_vld),
        .i_ax    (r2_magx),
        .i_ay    (r2_magy),
        .i_tag   (r2_tag),
        .o_valid (nd_vld),
        .o_nx    (nd_nx),
        .o_ny    (nd_ny),
        .o_k     (nd_k),
        .o_len   (nd_len),
        .o_tag   (nd_tag)
    );

    // stage 3: distance back in Q16.16 and the slowing-radius test
    logic [KW-1:0] w_dkm;
    logic [43:0]   w_dist;
    t_tag_b        n3_tag;
    logic          r3_vld;
    logic [30:0]   r3_dist;
    t_tag_b        r3_tag;

    always_comb begin
        w_dkm = nd_k[KW-1] ? KW'(-nd_k) : KW'(nd_k);
        if (nd_k[KW-1]) begin
            w_dist = 44'(nd_len) << w_dkm;
        end else begin
            w_dist = 44'(nd_len) >> w_dkm;
        end
        n3_tag.use_arr = nd_tag.arrive_en && (nd_len != '0) && (w_dist < 44'(nd_tag.rad));
        n3_tag.nx      = nd_nx;
        n3_tag.ny      = nd_ny;
        n3_tag.len     = nd_len;
        n3_tag.a       = nd_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_adv) begin
            r3_vld <= nd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_dist <= w_dist[30:0];
            r3_tag  <= n3_tag;
        end
    end

    // arrive speed = speed * dist / radius
    logic          ar_vld;
    logic [NW-1:0] ar_q;
    t_tag_b        ar_tag;

    sfu_muldiv #(
        .TW ($bits(t_tag_b))
    ) u_div_arrive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r3_vld),
        .i_a     (r3_tag.a.speed),
        .i_b     (r3_dist),
        .i_d     ({1'b0, r3_tag.a.rad}),
        .i_tag   (r3_tag),
        .o_valid (ar_vld),
        .o_q     (ar_q),
        .o_tag   (ar_tag)
    );

    // desired velocity = speed * n / len per axis
    logic [NW-1:0] w_speed2;
    t_tag_c        w_tag_c;
    logic          ds_vld;
    logic [NW-1:0] ds_qx;
    logic [NW-1:0] ds_qy;
    t_tag_c        ds_tag;

    always_comb begin
        w_speed2         = ar_tag.use_arr ? ar_q : ar_tag.a.speed;
        w_tag_c.len_zero = ar_tag.len == '0;
        w_tag_c.neg_x    = ar_tag.a.neg_x;
        w_tag_c.neg_y    = ar_tag.a.neg_y;
        w_tag_c.vel_x    = ar_tag.a.vel_x;
        w_tag_c.vel_y    = ar_tag.a.vel_y;
        w_tag_c.mf       = ar_tag.a.mf;
        w_tag_c.op_zero  = ar_tag.a.op_zero;
    end

    sfu_muldiv #(
        .TW ($bits(t_tag_c))
    ) u_div_des_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (ar_vld),
        .i_a     (w_speed2),
        .i_b     (ar_tag.nx),
        .i_d     (ar_tag.len),
        .i_tag   (w_tag_c),
        .o_valid (ds_vld),
        .o_q     (ds_qx),
        .o_tag   (ds_tag)
    );

    sfu_muldiv #(
        .TW (1)
    ) u_div_des_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (ar_vld),
        .i_a     (w_speed2),
        .i_b     (ar_tag.ny),
        .i_d     (ar_tag.len),
        .i_tag   (1'b0),
        .o_valid (),
        .o_q     (ds_qy),
        .o_tag   ()
    );

    // stage 5: steering vector = desired - current velocity
    logic signed [32:0] w_desx;
    logic signed [32:0] w_desy;
    t_tag_d             n5_tag;
    logic               r5_vld;
    t_tag_d             r5_tag;

    always_comb begin
        if (ds_tag.len_zero) begin
            w_desx = '0;
            w_desy = '0;
        end else begin
            w_desx = ds_tag.neg_x ? -$signed({2'b00, ds_qx}) : $signed({2'b00, ds_qx});
            w_desy = ds_tag.neg_y ? -$signed({2'b00, ds_qy}) : $signed({2'b00, ds_qy});
        end
        n5_tag.op_zero = ds_tag.op_zero;
        n5_tag.sx      = w_desx - {ds_tag.vel_x[31], ds_tag.vel_x};
        n5_tag.sy      = w_desy - {ds_tag.vel_y[31], ds_tag.vel_y};
        n5_tag.mf      = ds_tag.mf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_adv) begin
            r5_vld <= ds_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_tag <= n5_tag;
        end
    end

    // stage 6: steering magnitudes
    logic           r6_vld;
    logic [SMW-1:0] r6_magx;
    logic [SMW-1:0] r6_magy;
    t_tag_d         r6_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_adv) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_magx <= r5_tag.sx[32] ? SMW'(-r5_tag.sx) : SMW'(r5_tag.sx);
            r6_magy <= r5_tag.sy[32] ? SMW'(-r5_tag.sy) : SMW'(r5_tag.sy);
            r6_tag  <= r5_tag;
        end
    end

    // steering length
    logic                 ns_vld;
    logic [NW-1:0]        ns_nx;
    logic [NW-1:0]        ns_ny;
    logic signed [KW-1:0] ns_k;
    logic [LW-1:0]        ns_len;
    t_tag_d               ns_tag;

    sfu_norm #(
        .IW ($bits(r6_magx)),
        .TW ($bits(t_tag_d))
    ) u_norm_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r6_vld),
        .i_ax    (r6_magx),
        .i_ay    (r6_magy),
        .i_tag   (r6_tag),
        .o_valid (ns_vld),
        .o_nx    (ns_nx),
        .o_ny    (ns_ny),
        .o_k     (ns_k),
        .o_len   (ns_len),
        .o_tag   (ns_tag)
    );

    // stage 7: compare the steering length against max force
    logic [KW-1:0] w_skm;
    logic [63:0]   w_lhs;
    logic [63:0]   w_rhs;
    t_tag_e        n7_tag;
    logic          r7_vld;
    logic [NW-1:0] r7_nx;
    logic [NW-1:0] r7_ny;
    logic [LW-1:0] r7_len;
    logic [30:0]   r7_mf;
    t_tag_e        r7_tag;

    always_comb begin
        w_skm = ns_k[KW-1] ? KW'(-ns_k) : KW'(ns_k);
        if (ns_k[KW-1]) begin
            w_lhs = 64'(ns_len) << w_skm;
            w_rhs = 64'(ns_tag.mf);
        end else begin
            w_lhs = 64'(ns_len);
            w_rhs = 64'(ns_tag.mf) << w_skm;
        end
        n7_tag.over    = (ns_len != '0) && (w_lhs > w_rhs);
        n7_tag.op_zero = ns_tag.op_zero;
        n7_tag.sx      = ns_tag.sx;
        n7_tag.sy      = ns_tag.sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_adv) begin
            r7_vld <= ns_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_nx  <= ns_nx;
            r7_ny  <= ns_ny;
            r7_len <= ns_len;
            r7_mf  <= ns_tag.mf;
            r7_tag <= n7_tag;
        end
    end

    // clipped force = max_force * n / len per axis
    logic          cl_vld;
    logic [NW-1:0] cl_qx;
    logic [NW-1:0] cl_qy;
    t_tag_e        cl_tag;

    sfu_muldiv #(
        .TW ($bits(t_tag_e))
    ) u_div_clip_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r7_vld),
        .i_a     (r7_mf),
        .i_b     (r7_nx),
        .i_d     (r7_len),
        .i_tag   (r7_tag),
        .o_valid (cl_vld),
        .o_q     (cl_qx),
        .o_tag   (cl_tag)
    );

    sfu_muldiv #(
        .TW (1)
    ) u_div_clip_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r7_vld),
        .i_a     (r7_mf),
        .i_b     (r7_ny),
        .i_d     (r7_len),
        .i_tag   (1'b0),
        .o_valid (),
        .o_q     (cl_qy),
        .o_tag   ()
    );

    // stage 8: output register
    logic [31:0] n_fx;
    logic [31:0] n_fy;

    always_comb begin
        if (cl_tag.op_zero) begin
            n_fx = '0;
            n_fy = '0;
        end else if (cl_tag.over) begin
            n_fx = cl_tag.sx[32] ? -{1'b0, cl_qx} : {1'b0, cl_qx};
            n_fy = cl_tag.sy[32] ? -{1'b0, cl_qy} : {1'b0, cl_qy};
        end else begin
            n_fx = sat33(cl_tag.sx);
            n_fy = sat33(cl_tag.sy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= cl_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_force_x <= n_fx;
            o_force_y <= n_fy;
        end
    end

endmodule

// ----- rtl/sfu_isqrt.sv -----
// sfu_isqrt: pipelined integer square root, one root bit per stage.
// Depends on sfu_pkg for the root width; carries a sideband tag.
module sfu_isqrt #(
    parameter int unsigned TW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [2*sfu_pkg::LenW-1:0]  i_rad,
    input  logic [TW-1:0]               i_tag,
    output logic                        o_valid,
    output logic [sfu_pkg::LenW-1:0]    o_root,
    output logic [TW-1:0]               o_tag
);
    localparam int unsigned NS   = sfu_pkg::LenW;
    localparam int unsigned RadW = 2 * NS;
    localparam int unsigned RemW = NS + 3;

    logic            si_vld  [0:NS-1];
    logic [RemW-1:0] si_rem  [0:NS-1];
    logic [NS-1:0]   si_root [0:NS-1];
    logic [RadW-1:0] si_rad  [0:NS-1];
    logic [TW-1:0]   si_tag  [0:NS-1];

    logic            r_vld   [0:NS-1];
    logic [RemW-1:0] r_rem   [0:NS-1];
    logic [NS-1:0]   r_root  [0:NS-1];
    logic [RadW-1:0] r_rad   [0:NS-1];
    logic [TW-1:0]   r_tag   [0:NS-1];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [RemW-1:0] trial;
        logic [RemW-1:0] test;
        logic [RemW-1:0] n_rem;
        logic [NS-1:0]   n_root;

        if (s == 0) begin : g_first
            assign si_vld[s]  = i_valid;
            assign si_rem[s]  = '0;
            assign si_root[s] = '0;
            assign si_rad[s]  = i_rad;
            assign si_tag[s]  = i_tag;
        end else begin : g_next
            assign si_vld[s]  = r_vld[s-1];
            assign si_rem[s]  = r_rem[s-1];
            assign si_root[s] = r_root[s-1];
            assign si_rad[s]  = r_rad[s-1];
            assign si_tag[s]  = r_tag[s-1];
        end

        always_comb begin
            trial = {si_rem[s][RemW-3:0], si_rad[s][RadW-1 -: 2]};
            test  = RemW'({si_root[s], 2'b01});
            if (trial >= test) begin
                n_rem  = trial - test;
                n_root = {si_root[s][NS-2:0], 1'b1};
            end else begin
                n_rem  = trial;
                n_root = {si_root[s][NS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= si_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_rad[s]  <= {si_rad[s][RadW-3:0], 2'b00};
                r_tag[s]  <= si_tag[s];
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_tag   = r_tag[NS-1];

endmodule

// ----- rtl/sfu_norm.sv -----
// sfu_norm: scales a magnitude pair so the larger lies in [2^30, 2^31), then
// takes the length. Depends on sfu_pkg and sfu_isqrt.
module sfu_norm #(
    parameter int unsigned IW = 43,
    parameter int unsigned TW = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [IW-1:0]                      i_ax,
    input  logic [IW-1:0]                      i_ay,
    input  logic [TW-1:0]                      i_tag,
    output logic                               o_valid,
    output logic [sfu_pkg::NrmW-1:0]           o_nx,
    output logic [sfu_pkg::NrmW-1:0]           o_ny,
    output logic signed [sfu_pkg::KW-1:0]      o_k,
    output logic [sfu_pkg::LenW-1:0]           o_len,
    output logic [TW-1:0]                      o_tag
);
    localparam int unsigned NW = sfu_pkg::NrmW;
    localparam int unsigned KW = sfu_pkg::KW;
    localparam int unsigned PW = $clog2(IW);
    localparam int unsigned EW = IW + NW;
    localparam int unsigned IT = TW + 2 * NW + KW;

    // stage a: leading one of the pair
    logic [IW-1:0] w_or;
    logic [PW-1:0] n_a_p;
    logic          r_a_vld;
    logic [IW-1:0] r_a_ax;
    logic [IW-1:0] r_a_ay;
    logic [PW-1:0] r_a_p;
    logic          r_a_nz;
    logic [TW-1:0] r_a_tag;

    assign w_or = i_ax | i_ay;

    always_comb begin
        n_a_p = '0;
        for (int i = 0; i < IW; i++) begin
            if (w_or[i]) begin
                n_a_p = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ax  <= i_ax;
            r_a_ay  <= i_ay;
            r_a_p   <= n_a_p;
            r_a_nz  <= |w_or;
            r_a_tag <= i_tag;
        end
    end

    // stage b: shift the pair so the leading one lands on bit 30
    logic [EW-1:0]        w_ext_x;
    logic [EW-1:0]        w_ext_y;
    logic [EW-1:0]        w_sh_x;
    logic [EW-1:0]        w_sh_y;
    logic signed [KW-1:0] n_b_k;
    logic                 r_b_vld;
    logic [NW-1:0]        r_b_nx;
    logic [NW-1:0]        r_b_ny;
    logic signed [KW-1:0] r_b_k;
    logic [TW-1:0]        r_b_tag;

    assign w_ext_x = EW'(r_a_ax);
    assign w_ext_y = EW'(r_a_ay);

    always_comb begin
        if (r_a_p >= PW'(NW - 1)) begin
            w_sh_x = w_ext_x >> (r_a_p - PW'(NW - 1));
            w_sh_y = w_ext_y >> (r_a_p - PW'(NW - 1));
        end else begin
            w_sh_x = w_ext_x << (PW'(NW - 1) - r_a_p);
            w_sh_y = w_ext_y << (PW'(NW - 1) - r_a_p);
        end
        if (r_a_nz) begin
            n_b_k = KW'(NW - 1) - KW'(r_a_p);
        end else begin
            n_b_k = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_nx  <= w_sh_x[NW-1:0];
            r_b_ny  <= w_sh_y[NW-1:0];
            r_b_k   <= n_b_k;
            r_b_tag <= r_a_tag;
        end
    end

    // stage c: squares
    logic                 r_c_vld;
    logic [2*NW-1:0]      r_c_sqx;
    logic [2*NW-1:0]      r_c_sqy;
    logic [NW-1:0]        r_c_nx;
    logic [NW-1:0]        r_c_ny;
    logic signed [KW-1:0] r_c_k;
    logic [TW-1:0]        r_c_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_sqx <= r_b_nx * r_b_nx;
            r_c_sqy <= r_b_ny * r_b_ny;
            r_c_nx  <= r_b_nx;
            r_c_ny  <= r_b_ny;
            r_c_k   <= r_b_k;
            r_c_tag <= r_b_tag;
        end
    end

    // stage d: sum of squares
    logic                 r_d_vld;
    logic [2*NW:0]        r_d_sum;
    logic [IT-1:0]        r_d_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_sum <= (2*NW+1)'(r_c_sqx) + (2*NW+1)'(r_c_sqy);
            r_d_tag <= {r_c_tag, r_c_nx, r_c_ny, r_c_k};
        end
    end

    logic [IT-1:0] w_sq_tag;

    sfu_isqrt #(
        .TW (IT)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_d_vld),
        .i_rad   ((2*sfu_pkg::LenW)'(r_d_sum)),
        .i_tag   (r_d_tag),
        .o_valid (o_valid),
        .o_root  (o_len),
        .o_tag   (w_sq_tag)
    );

    assign o_k   = w_sq_tag[KW-1:0];
    assign o_ny  = w_sq_tag[KW +: NW];
    assign o_nx  = w_sq_tag[KW+NW +: NW];
    assign o_tag = w_sq_tag[IT-1 -: TW];

endmodule

// ----- rtl/sfu_muldiv.sv -----
// sfu_muldiv: floor(a * b / d) with a registered product and a restoring
// divider, one quotient bit per stage. Depends on sfu_pkg.
module sfu_muldiv #(
    parameter int unsigned TW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [sfu_pkg::NrmW-1:0]  i_a,
    input  logic [sfu_pkg::NrmW-1:0]  i_b,
    input  logic [sfu_pkg::LenW-1:0]  i_d,
    input  logic [TW-1:0]             i_tag,
    output logic                      o_valid,
    output logic [sfu_pkg::NrmW-1:0]  o_q,
    output logic [TW-1:0]             o_tag
);
    localparam int unsigned QW = sfu_pkg::NrmW;
    localparam int unsigned DW = sfu_pkg::LenW;
    localparam int unsigned PW = 2 * QW;

    logic          r_p_vld;
    logic [PW-1:0] r_p_prod;
    logic [DW-1:0] r_p_d;
    logic [TW-1:0] r_p_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_prod <= i_a * i_b;
            r_p_d    <= i_d;
            r_p_tag  <= i_tag;
        end
    end

    // The quotient is known to fit QW bits, so the top half of the
    // product starts below the divisor.
    logic          si_vld [0:QW-1];
    logic [DW-1:0] si_rem [0:QW-1];
    logic [QW-1:0] si_low [0:QW-1];
    logic [QW-1:0] si_q   [0:QW-1];
    logic [DW-1:0] si_d   [0:QW-1];
    logic [TW-1:0] si_tag [0:QW-1];

    logic          r_vld  [0:QW-1];
    logic [DW-1:0] r_rem  [0:QW-1];
    logic [QW-1:0] r_low  [0:QW-1];
    logic [QW-1:0] r_q    [0:QW-1];
    logic [DW-1:0] r_d    [0:QW-1];
    logic [TW-1:0] r_tag  [0:QW-1];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign si_vld[s] = r_p_vld;
            assign si_rem[s] = DW'(r_p_prod[PW-1:QW]);
            assign si_low[s] = r_p_prod[QW-1:0];
            assign si_q[s]   = '0;
            assign si_d[s]   = r_p_d;
            assign si_tag[s] = r_p_tag;
        end else begin : g_next
            assign si_vld[s] = r_vld[s-1];
            assign si_rem[s] = r_rem[s-1];
            assign si_low[s] = r_low[s-1];
            assign si_q[s]   = r_q[s-1];
            assign si_d[s]   = r_d[s-1];
            assign si_tag[s] = r_tag[s-1];
        end

        always_comb begin
            trial = {si_rem[s], si_low[s][QW-1]};
            diff  = trial - {1'b0, si_d[s]};
            ge    = trial >= {1'b0, si_d[s]};
            n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= si_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_low[s] <= {si_low[s][QW-2:0], 1'b0};
                r_q[s]   <= {si_q[s][QW-2:0], ge};
                r_d[s]   <= si_d[s];
                r_tag[s] <= si_tag[s];
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

// ----- rtl/sfu_checker.sv -----
// sfu_checker: port-level checks of the steering force unit, bound to the top.
// Depends only on the top level's ports.
module sfu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_force_x,
    input logic [31:0] o_force_y
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_force_x) && $stable(o_force_y))
        else $error("output word changed while stalled");

    // input side stalls exactly when a finished word is held back
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("o_ready does not track output backpressure");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // no word appears during an output stall; one shown after a stall was already waiting
    a_stall_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !$past(o_ready) |-> $past(o_valid))
        else $error("word appeared during a stall");

    // an offered input word stays offered until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("input word withdrawn before acceptance");

endmodule

bind steering_force_unit_top sfu_checker u_sfu_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_force_x (o_force_x),
    .o_force_y (o_force_y)
);
